FILE: rtl/era_pkg.sv
// Shared constants and stage payload types for the extended real adder.
`timescale 1ns / 1ps
package era_pkg;
  localparam int WordW = 16;
  localparam int MantW = 64;
  localparam int GapW  = 15;
  localparam int LzW   = 6;
  localparam logic [WordW-1:0] ExpMask = 16'h7fff;
  localparam logic [WordW-1:0] SignBit = 16'h8000;
  localparam logic [WordW-1:0] WordInc = 16'd2;

  // Aligned operands after the compare and shift stage.
  typedef struct packed {
    logic             bypass;
    logic [WordW-1:0] wa;
    logic [MantW-1:0] ma;
    logic [WordW-1:0] wb;
    logic [MantW-1:0] mb;
  } align_t;

  // Sum and the word it belongs to.
  typedef struct packed {
    logic             bypass;
    logic [WordW-1:0] wa;
    logic [MantW-1:0] sum;
  } add_t;

  // Magnitude with its leading zero count.
  typedef struct packed {
    logic             bypass;
    logic             zero;
    logic [WordW-1:0] wa;
    logic [MantW-1:0] mag;
    logic [LzW-1:0]   lz;
  } mag_t;

  function automatic logic [LzW-1:0] lead_zeros(input logic [MantW-1:0] v);
    logic [LzW-1:0] n;
    logic found;
    n = '0;
    found = 1'b0;
    for (int i = MantW - 1; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = LzW'(MantW - 1 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction
endpackage

FILE: rtl/extended_real_add.sv
// Top level of the pipelined x87 extended real adder.
`timescale 1ns / 1ps
// Adds two 80-bit extended reals with the truncating 62-bit method: the operand
// with the larger exponent is kept, the other is shifted right by the gap, both
// are turned into signed 62-bit form and added, then the sum is normalized with
// no rounding. The datapath is four register stages (align, add, magnitude and
// leading-zero count, normalize shift), and a new beat can enter every cycle
// while the output is not stalled. A stall on the output holds the pipeline in
// place with nothing lost or repeated.
module extended_real_add
  import era_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // first_sign_exponent[15:0], first_mantissa[79:16],
  // second_sign_exponent[95:80], second_mantissa[159:96]
  input  logic [159:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // sum_sign_exponent[15:0], sum_mantissa[79:16]
  output logic [79:0]  m_tdata
);
  logic [WordW-1:0] w1, w2, x1, x2;
  logic [MantW-1:0] m1, m2;
  align_t a_in, a_q;
  add_t   b_in, b_q;
  mag_t   c_in, c_q;
  logic [79:0] d_in;
  logic v1, v2, v3, r1, r2, r3;

  assign w1 = s_tdata[15:0];
  assign m1 = s_tdata[79:16];
  assign w2 = s_tdata[95:80];
  assign m2 = s_tdata[159:96];
  assign x1 = w1 & ExpMask;
  assign x2 = w2 & ExpMask;

  // Stage one: pick A, align B. A tie takes the second operand as A.
  always_comb begin
    logic [GapW-1:0] gap;
    if (x1 > x2) begin
      gap = GapW'(x1 - x2);
      a_in.wa = w1; a_in.ma = m1; a_in.wb = w2; a_in.mb = m2;
    end else begin
      gap = GapW'(x2 - x1);
      a_in.wa = w2; a_in.ma = m2; a_in.wb = w1; a_in.mb = m1;
    end
    a_in.bypass = gap >= GapW'(MantW);
    if (!a_in.bypass) a_in.mb = a_in.mb >> gap[LzW-1:0];
  end

  era_stage #(.Width($bits(align_t))) u_s1 (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready), .in_data(a_in),
    .out_valid(v1), .out_ready(r1), .out_data(a_q));

  // Stage two: signed form of each operand and the sum.
  always_comb begin
    logic [WordW-1:0] wa2, wb2;
    logic [MantW-1:0] sa, sb;
    wa2 = a_q.wa + WordInc;
    wb2 = a_q.wb + WordInc;
    sa = a_q.ma >> 2;
    sb = a_q.mb >> 2;
    if (wa2[WordW-1]) sa = -sa;
    if (wb2[WordW-1]) sb = -sb;
    b_in.bypass = a_q.bypass;
    b_in.wa  = a_q.bypass ? a_q.wa : (wa2 & ExpMask);
    b_in.sum = a_q.bypass ? a_q.ma : sa + sb;
  end

  era_stage #(.Width($bits(add_t))) u_s2 (
    .clk, .rst, .in_valid(v1), .in_ready(r1), .in_data(b_in),
    .out_valid(v2), .out_ready(r2), .out_data(b_q));

  // Stage three: magnitude, sign and leading zero count.
  always_comb begin
    c_in.bypass = b_q.bypass;
    c_in.zero = b_q.sum == '0;
    c_in.wa  = b_q.wa;
    c_in.mag = b_q.sum;
    if (!b_q.bypass && b_q.sum[MantW-1]) begin
      c_in.mag = -b_q.sum;
      c_in.wa  = b_q.wa | SignBit;
    end
    c_in.lz = lead_zeros(c_in.mag);
  end

  era_stage #(.Width($bits(mag_t))) u_s3 (
    .clk, .rst, .in_valid(v2), .in_ready(r2), .in_data(c_in),
    .out_valid(v3), .out_ready(r3), .out_data(c_q));

  // Stage four: normalize shift and exponent adjust.
  always_comb begin
    if (c_q.bypass) begin
      d_in = {c_q.mag, c_q.wa};
    end else if (c_q.zero) begin
      d_in = '0;
    end else begin
      d_in = {c_q.mag << c_q.lz, c_q.wa - WordW'(c_q.lz)};
    end
  end

  era_stage #(.Width(80)) u_s4 (
    .clk, .rst, .in_valid(v3), .in_ready(r3), .in_data(d_in),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata));

  // A nonzero sum that went through the adder leaves normalized; a large-gap
  // bypass passes A through untouched and is not checked here.
  a_norm: assert property (@(posedge clk) disable iff (rst)
    v3 && !c_q.bypass && !c_q.zero |-> d_in[79]) else $error("not normalized");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed while stalled");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    v3 && !r3 |=> v3 && $stable(c_q)) else $error("stage three lost a beat");
endmodule

FILE: rtl/era_stage.sv
// One elastic pipeline register slot with valid and stall handling.
`timescale 1ns / 1ps
module era_stage
  import era_pkg::*;
#(
  parameter int Width = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [Width-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [Width-1:0] out_data
);
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= in_data;
    end
  end
endmodule
